[sv/nmrl_pkg.sv]
// Shared types, constants and nibble helpers for the nibble machine run length core.
package nmrl_pkg;

  localparam int NIB_W   = 4;
  localparam int NIBS    = 16;
  localparam int ADDR_W  = 4;
  localparam int TAPE_W  = NIB_W * NIBS;
  localparam int LIMIT_MAX_W = 16;

  typedef logic [NIB_W-1:0]  nib_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [TAPE_W-1:0] tape_t;

  typedef enum logic [3:0] {
    OP_HALT  = 4'h0,
    OP_INC0  = 4'h1,
    OP_DEC0  = 4'h2,
    OP_INC1  = 4'h3,
    OP_DEC1  = 4'h4,
    OP_ADD   = 4'h5,
    OP_SUB   = 4'h6,
    OP_NOP   = 4'h7,
    OP_BNZ   = 4'h8,
    OP_BZ    = 4'h9,
    OP_LDI0  = 4'hA,
    OP_LDI1  = 4'hB,
    OP_ST0   = 4'hC,
    OP_ST1   = 4'hD,
    OP_SWP0  = 4'hE,
    OP_SWP1  = 4'hF
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_t;

  function automatic nib_t nib_get(tape_t t, addr_t i);
    return t[i*NIB_W +: NIB_W];
  endfunction

  function automatic tape_t nib_set(tape_t t, addr_t i, nib_t v);
    tape_t r;
    r = t;
    r[i*NIB_W +: NIB_W] = v;
    return r;
  endfunction

endpackage

[sv/nibble_machine_run_length_core.sv]
// Top level: runs the 4-bit nibble machine on one tape and reports its step count.
// A transfer is taken when start is high and busy is low. The machine then executes
// one instruction per clock cycle on a shared 4-bit adder. A run ends on a halt or
// once steps reach step_limit; busy then falls and done pulses for one cycle with
// step_count and hit_limit. At most step_limit steps run (65535 at the reset limit).
// The result is shown for that single cycle only, since the receiver cannot stall.
// The user writes step_limit through step_limit_we while idle; nothing enforces it.
module nibble_machine_run_length_core #(
  parameter int STEP_WIDTH = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    step_limit_we,
  input  logic [STEP_WIDTH-1:0]   step_limit,
  input  logic                    start,
  output logic                    busy,
  input  nmrl_pkg::tape_t         program_tape,
  output logic                    done,
  output logic [STEP_WIDTH-1:0]   step_count,
  output logic                    hit_limit
);
  import nmrl_pkg::*;

  localparam int LIMIT_W = (STEP_WIDTH < LIMIT_MAX_W) ? STEP_WIDTH : LIMIT_MAX_W;

  state_t                state;
  logic [STEP_WIDTH-1:0] limit;
  logic [STEP_WIDTH-1:0] steps;
  tape_t                 tape;
  addr_t                 pc;
  nib_t                  r0;
  nib_t                  r1;
  logic                  halted;

  op_t   op;
  addr_t pc1;
  addr_t pc2;
  nib_t  arg;
  nib_t  mem;
  logic  at_limit;
  nib_t  alu_a;
  nib_t  alu_b;
  logic  alu_cin;
  nib_t  alu_sum;

  assign busy = (state == S_RUN);

  // Instruction decode: opcode, operand and the nibble the operand addresses.
  always_comb begin
    op       = op_t'(nib_get(tape, pc));
    pc1      = pc + addr_t'(1);
    pc2      = pc1 + addr_t'(1);
    arg      = nib_get(tape, pc1);
    mem      = nib_get(tape, addr_t'(arg));
    at_limit = (steps == limit);
  end

  // The one adder serves every register arithmetic opcode.
  always_comb begin
    alu_a   = r0;
    alu_b   = r1;
    alu_cin = 1'b0;
    case (op)
      OP_INC0: begin
        alu_b = nib_t'(1);
      end
      OP_DEC0: begin
        alu_b = '1;
      end
      OP_INC1: begin
        alu_a = r1;
        alu_b = nib_t'(1);
      end
      OP_DEC1: begin
        alu_a = r1;
        alu_b = '1;
      end
      OP_SUB: begin
        alu_b   = ~r1;
        alu_cin = 1'b1;
      end
      default: begin
        alu_b = r1;
      end
    endcase
    alu_sum = alu_a + alu_b + nib_t'(alu_cin);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= STEP_WIDTH'({LIMIT_W{1'b1}});
    end else if (step_limit_we) begin
      limit <= STEP_WIDTH'(step_limit[LIMIT_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (halted || at_limit) begin
            state <= S_IDLE;
            done  <= 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      if (start) begin
        tape   <= program_tape;
        pc     <= '0;
        r0     <= '0;
        r1     <= '0;
        steps  <= '0;
        halted <= 1'b0;
      end
    end else if (halted || at_limit) begin
      step_count <= steps;
      hit_limit  <= at_limit;
    end else begin
      steps <= steps + STEP_WIDTH'(1);
      case (op)
        OP_HALT: begin
          halted <= 1'b1;
        end
        OP_INC0, OP_DEC0, OP_ADD, OP_SUB: begin
          r0 <= alu_sum;
          pc <= pc1;
        end
        OP_INC1, OP_DEC1: begin
          r1 <= alu_sum;
          pc <= pc1;
        end
        OP_NOP: begin
          pc <= pc1;
        end
        OP_BNZ: begin
          pc <= (r0 != '0) ? addr_t'(arg) : pc2;
        end
        OP_BZ: begin
          pc <= (r0 == '0) ? addr_t'(arg) : pc2;
        end
        OP_LDI0: begin
          r0 <= arg;
          pc <= pc2;
        end
        OP_LDI1: begin
          r1 <= arg;
          pc <= pc2;
        end
        OP_ST0: begin
          tape <= nib_set(tape, addr_t'(arg), r0);
          pc   <= pc2;
        end
        OP_ST1: begin
          tape <= nib_set(tape, addr_t'(arg), r1);
          pc   <= pc2;
        end
        OP_SWP0: begin
          tape <= nib_set(tape, addr_t'(arg), r0);
          r0   <= mem;
          pc   <= pc2;
        end
        default: begin
          tape <= nib_set(tape, addr_t'(arg), r1);
          r1   <= mem;
          pc   <= pc2;
        end
      endcase
    end
  end

endmodule

[sv/nmrl_checker.sv]
// Port-level checks on the run length core's transfer sequencing, with their bind.
module nmrl_checker #(
  parameter int STEP_WIDTH = 16
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  start,
  input logic                  busy,
  input logic                  done,
  input logic [STEP_WIDTH-1:0] step_count,
  input logic                  hit_limit
);

  // An accepted tape makes the core busy on the next cycle.
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted tape did not make the core busy");

  // A result is presented only once the run has ended.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while still running");

  // A run ends only with a result transfer.
  a_end_done: assert property (@(posedge clk) disable iff (rst)
    ($fell(busy) && !$past(rst)) |-> done)
    else $error("run ended without a result");

  // A run without a single step can only come from the limit.
  a_zero_limit: assert property (@(posedge clk) disable iff (rst)
    (done && step_count == '0) |-> hit_limit)
    else $error("zero steps reported without the limit flag");

  // No two results come on consecutive cycles.
  a_done_gap: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("results on consecutive cycles");

endmodule

bind nibble_machine_run_length_core nmrl_checker #(
  .STEP_WIDTH(STEP_WIDTH)
) u_nmrl_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .done       (done),
  .step_count (step_count),
  .hit_limit  (hit_limit)
);

[test/nibble_machine_run_length_core_test.sv]
// Self-checking testbench for the nibble machine run length core.
`timescale 1ns / 100ps

module nibble_machine_run_length_core_test;
  import nmrl_pkg::*;

  typedef struct {
    logic [15:0] step_count;
    logic        hit_limit;
  } run_outcome_t;

  // Keeps its own copy of the step limit, predicts every accepted tape and
  // checks the results in order.
  class run_scoreboard;
    logic [15:0]  step_cap = 16'hFFFF;
    run_outcome_t expected_runs[$];
    int           errors = 0;
    int           runs = 0;
    int           limit_hits = 0;

    function run_outcome_t run_machine(tape_t tape_in);
      tape_t        tape;
      nib_t         pc, r0, r1, arg, tmp;
      op_t          op;
      int unsigned  steps;
      bit           halted;
      run_outcome_t res;
      tape = tape_in;
      pc = '0;
      r0 = '0;
      r1 = '0;
      steps = 0;
      halted = 0;
      while (!halted && steps < step_cap) begin
        op = op_t'(tape[int'(pc)*4 +: 4]);
        case (op)
          OP_HALT: halted = 1;
          OP_INC0: begin r0 = r0 + 1'b1; pc = pc + 1'b1; end
          OP_DEC0: begin r0 = r0 - 1'b1; pc = pc + 1'b1; end
          OP_INC1: begin r1 = r1 + 1'b1; pc = pc + 1'b1; end
          OP_DEC1: begin r1 = r1 - 1'b1; pc = pc + 1'b1; end
          OP_ADD:  begin r0 = r0 + r1; pc = pc + 1'b1; end
          OP_SUB:  begin r0 = r0 - r1; pc = pc + 1'b1; end
          OP_NOP:  pc = pc + 1'b1;
          default: begin
            // Two-nibble instructions: the operand may wrap to nibble 0.
            pc = pc + 1'b1;
            arg = tape[int'(pc)*4 +: 4];
            pc = pc + 1'b1;
            case (op)
              OP_BNZ:  if (r0 != 0) pc = arg;
              OP_BZ:   if (r0 == 0) pc = arg;
              OP_LDI0: r0 = arg;
              OP_LDI1: r1 = arg;
              OP_ST0:  tape[int'(arg)*4 +: 4] = r0;
              OP_ST1:  tape[int'(arg)*4 +: 4] = r1;
              OP_SWP0: begin
                tmp = r0;
                r0 = tape[int'(arg)*4 +: 4];
                tape[int'(arg)*4 +: 4] = tmp;
              end
              default: begin
                tmp = r1;
                r1 = tape[int'(arg)*4 +: 4];
                tape[int'(arg)*4 +: 4] = tmp;
              end
            endcase
          end
        endcase
        steps++;
      end
      res.step_count = steps[15:0];
      res.hit_limit = (steps == step_cap);
      return res;
    endfunction

    function void note_tape(tape_t tape);
      run_outcome_t res;
      res = run_machine(tape);
      if (res.hit_limit) limit_hits++;
      runs++;
      expected_runs.push_back(res);
    endfunction

    function void check_result(logic [15:0] step_count, logic hit_limit);
      run_outcome_t exp_run;
      if (expected_runs.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: result with no run pending: step_count=%0d hit_limit=%b",
                   step_count, hit_limit);
        return;
      end
      exp_run = expected_runs.pop_front();
      if (step_count !== exp_run.step_count || hit_limit !== exp_run.hit_limit) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: step_count=%0d hit_limit=%b, expected step_count=%0d hit_limit=%b",
                   step_count, hit_limit, exp_run.step_count, exp_run.hit_limit);
      end
    endfunction

    function int pending();
      return expected_runs.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        step_limit_we;
  logic [15:0] step_limit;
  logic        start;
  logic        busy;
  tape_t       program_tape;
  logic        done;
  logic [15:0] step_count;
  logic        hit_limit;

  run_scoreboard sb = new();
  int            limit_settings = 0;

  nibble_machine_run_length_core i_dut (
    .clk           (clk),
    .rst           (rst),
    .step_limit_we (step_limit_we),
    .step_limit    (step_limit),
    .start         (start),
    .busy          (busy),
    .program_tape  (program_tape),
    .done          (done),
    .step_count    (step_count),
    .hit_limit     (hit_limit)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Transfers and results are both observed at the rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_result(step_count, hit_limit);
      if (start && !busy) sb.note_tape(program_tape);
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_tape(tape_t tape, bit may_idle);
    if (may_idle && $urandom_range(0, 99) < 23) begin
      start = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    start = 1'b1;
    program_tape = tape;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic write_limit(logic [15:0] value);
    start = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
    step_limit_we = 1'b1;
    step_limit = value;
    @(negedge clk);
    step_limit_we = 1'b0;
    sb.step_cap = value;
    limit_settings++;
  endtask

  initial begin
    tape_t tape;
    op_t   op;
    int    sent;
    int    phase;
    int    phase_items;
    int    k;
    rst = 1'b1;
    step_limit_we = 1'b0;
    step_limit = '0;
    start = 1'b0;
    program_tape = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset limit: an immediate halt and a loop that never ends.
    send_tape(64'h0, 1'b1);
    send_tape({60'h0, OP_BZ}, 1'b1);

    // A zero limit runs nothing at all.
    write_limit(16'd0);
    send_tape(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);

    // With a limit of one, a halt lands on the last allowed step.
    write_limit(16'd1);
    send_tape(64'h0, 1'b1);

    write_limit(16'd16);
    op = OP_INC0;
    repeat (15) begin
      tape = {$urandom, $urandom};
      tape[3:0] = op;
      send_tape(tape, 1'b1);
      op = op.next();
    end
    // Fifteen no-ops and a halt use up exactly the limit.
    send_tape(64'h0777_7777_7777_7777, 1'b1);
    // Load immediate at nibble 15 takes its operand from nibble 0.
    send_tape(64'hA777_7777_7777_7777, 1'b1);
    send_tape(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);

    sent = 0;
    phase = 0;
    while (sent < 100) begin
      if (phase == 2 || phase == 6) begin
        write_limit(16'hFFFF);
        phase_items = 2;
      end else begin
        case ($urandom_range(0, 3))
          0:       write_limit(16'd1);
          1:       write_limit(16'($urandom_range(2, 64)));
          default: write_limit(16'($urandom_range(65, 1000)));
        endcase
        phase_items = $urandom_range(8, 16);
      end
      repeat (phase_items) begin
        tape = {$urandom, $urandom};
        case ($urandom_range(0, 9))
          0, 1, 2: ;
          3, 4, 5, 6: begin
            // Random code with a halt placed somewhere in nibbles 2 to 15.
            k = $urandom_range(2, 15);
            tape[k*4 +: 4] = OP_HALT;
          end
          7, 8: begin
            // Counted loop: load r0, decrement until zero, then halt.
            tape[23:0] = {OP_HALT, 4'h2, OP_BNZ, OP_DEC0, 4'($urandom), OP_LDI0};
          end
          default: begin
            // No halt in sight, so these runs tend to be long.
            for (k = 0; k < 16; k++)
              if (tape[k*4 +: 4] == OP_HALT) tape[k*4 +: 4] = OP_NOP;
          end
        endcase
        // A long stretch of back-to-back transfers with no idling.
        send_tape(tape, !(sent >= 30 && sent < 55));
        sent++;
      end
      phase++;
    end
    start = 1'b0;

    while (sb.pending() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    $display("Ran %0d tapes under %0d step limit settings; %0d runs reached the limit.",
             sb.runs, limit_settings, sb.limit_hits);
    if (sb.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches in total.", sb.errors);
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("Timeout with %0d results still pending.", sb.pending());
    $display("FAILED: results differ");
    $finish;
  end

endmodule
